// ----- sv/pbf_pkg.sv -----
// ---------------------------------------------------------------------------
// pbf_pkg: shared constants and types for the palette framebuffer blitter
// Sizes, transaction codes, register indexes and the palette write bundle.
// ---------------------------------------------------------------------------
package pbf_pkg;

    // Sizing
    localparam int PALETTE_ENTRIES = 256;
    localparam int LANES           = 4;
    localparam int MAX_BUFFERS     = 3;

    localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);
    localparam int WORD_LANES = 4;                      // 8-bit indices in one word
    localparam int RD_PORTS   = (LANES < WORD_LANES) ? LANES : WORD_LANES;

    // Stream widths (whole bytes)
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 112;

    // Field widths
    localparam int ADDR_W = 26;
    localparam int PAN_W  = 14;
    localparam int CFG_W  = 13;

    // Transaction kinds carried on the input tuser
    localparam logic [1:0] ACT_PAL_WR = 2'd0;
    localparam logic [1:0] ACT_REGION = 2'd1;
    localparam logic [1:0] ACT_PIXELS = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DST_PITCH    = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BUFFER_COUNT = 2'd2;

    // Register reset values
    localparam logic [12:0] RST_DST_PITCH    = 13'd800;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd600;
    localparam logic [1:0]  RST_BUFFER_COUNT = 2'd1;

    // Palette write bundle
    typedef struct packed {
        logic        en;
        logic [7:0]  idx;
        logic [23:0] rgb;
    } t_pal_wr;

    // RGB888 to RGB565: keep the top 5/6/5 bits
    function automatic logic [15:0] rgb565(input logic [23:0] c);
        rgb565 = {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

// ----- sv/palette_blit_to_framebuffer.sv -----
// ---------------------------------------------------------------------------
// palette_blit_to_framebuffer: palettised / direct blitter into RGB565 buffers
// Palette writes, region clipping and the row/column walk that turns pixel
// groups into framebuffer words with page-flip requests.
// ---------------------------------------------------------------------------
// Usage
//   s_axis: one transaction per item; tuser selects palette write, region
//   start or pixel group. Only pixel groups inside an active region give a
//   result on m_axis: address, up to four RGB565 pixels, count, tlast on the
//   final group of the region and tuser set when a pan (pan_offset) is due.
//   Config port: write dst_pitch, frame_height, buffer_count while idle.
// Timing
//   One item per cycle sustained while the output is not stalled. A result
//   passes through the middle stage (palette memory read) and then the
//   output register. All region state is updated in the accepting cycle,
//   so back-to-back items need no stall.
// Reset
//   Synchronous; clears the palette valid bits at once (no sweep), the
//   region state, buffer index and pipeline, and loads register defaults.
// Stall
//   When m_axis_tready is low the output holds; the middle stage still fills,
//   after which s_axis_tready drops until the output drains.
// ---------------------------------------------------------------------------
module palette_blit_to_framebuffer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Config write port
    input  logic                            i_cfg_wr_en,
    input  logic [1:0]                      i_cfg_index,
    input  logic [pbf_pkg::CFG_W-1:0]       i_cfg_wr_data,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: pal_index[7:0], color_rgb[31:8], rect_left[44:32], rect_top[57:45],
    //        rect_right[70:58], rect_bottom[83:71], surf_width[95:84],
    //        surf_height[107:96], bytes_per_pixel[109:108], src_word[141:110],
    //        lane_count[144:142], zero pad
    input  logic [pbf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,   // action[1:0]
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: dst_address[25:0], pixel_data[89:26], pixel_count[92:90],
    //        pan_offset[106:93], zero pad
    output logic [pbf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,   // region_last
    output logic                            m_axis_tuser    // flip
);
    import pbf_pkg::*;

    // ---------------- input field unpacking ----------------
    logic [7:0]         w_pal_index;
    logic [23:0]        w_color;
    logic signed [12:0] w_rl, w_rt, w_rr, w_rb;
    logic [11:0]        w_sw, w_sh;
    logic [1:0]         w_bpp;
    logic [31:0]        w_src;
    logic [2:0]         w_lanes_in;

    assign w_pal_index = s_axis_tdata[7:0];
    assign w_color     = s_axis_tdata[31:8];
    assign w_rl        = $signed(s_axis_tdata[44:32]);
    assign w_rt        = $signed(s_axis_tdata[57:45]);
    assign w_rr        = $signed(s_axis_tdata[70:58]);
    assign w_rb        = $signed(s_axis_tdata[83:71]);
    assign w_sw        = s_axis_tdata[95:84];
    assign w_sh        = s_axis_tdata[107:96];
    assign w_bpp       = s_axis_tdata[109:108];
    assign w_src       = s_axis_tdata[141:110];
    assign w_lanes_in  = s_axis_tdata[144:142];

    // ---------------- registers ----------------
    logic [12:0]       r_dst_pitch, r_frame_height;
    logic [1:0]        r_buffer_count;
    logic [ADDR_W-1:0] r_frame_size;

    logic [1:0]        r_buffer_index, n_buffer_index;
    logic              r_active, n_active;
    logic              r_mode16, n_mode16;
    logic              r_full, n_full;
    logic [12:0]       r_width, n_width;
    logic [12:0]       r_rows, n_rows;
    logic [12:0]       r_column, n_column;
    logic [ADDR_W-1:0] r_row_addr, n_row_addr;

    // Middle stage (palette read in flight)
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [2:0]        r_s1_count;
    logic              r_s1_last, r_s1_flip, r_s1_mode16;
    logic [PAN_W-1:0]  r_s1_pan;
    logic [31:0]       r_s1_src;

    // Output register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [63:0]       r_out_data;
    logic [2:0]        r_out_count;
    logic              r_out_last, r_out_flip;
    logic [PAN_W-1:0]  r_out_pan;

    // ---------------- handshake ----------------
    logic w_adv_out, w_adv1, w_accept;
    assign w_adv_out     = !r_out_valid || m_axis_tready;
    assign w_adv1        = !r_s1_valid || w_adv_out;
    assign s_axis_tready = w_adv1;
    assign w_accept      = s_axis_tvalid && w_adv1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_pitch    <= RST_DST_PITCH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_buffer_count <= RST_BUFFER_COUNT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DST_PITCH:    r_dst_pitch    <= i_cfg_wr_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wr_data;
                CFG_BUFFER_COUNT: r_buffer_count <= i_cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    // Buffer size in pixels, taken from the values the registers are about to hold
    logic [12:0] w_fs_pitch, w_fs_height;
    assign w_fs_pitch  = (i_cfg_wr_en && i_cfg_index == CFG_DST_PITCH) ?
                         i_cfg_wr_data : r_dst_pitch;
    assign w_fs_height = (i_cfg_wr_en && i_cfg_index == CFG_FRAME_HEIGHT) ?
                         i_cfg_wr_data : r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= ADDR_W'(RST_DST_PITCH) * ADDR_W'(RST_FRAME_HEIGHT);
        end else begin
            r_frame_size <= ADDR_W'(w_fs_pitch) * ADDR_W'(w_fs_height);
        end
    end

    // ---------------- palette ----------------
    t_pal_wr                       w_pal_wr;
    logic [RD_PORTS-1:0][7:0]      w_rd_idx;
    logic [RD_PORTS-1:0][15:0]     w_rd_data;

    assign w_pal_wr.en  = w_accept && (s_axis_tuser == ACT_PAL_WR);
    assign w_pal_wr.idx = w_pal_index;
    assign w_pal_wr.rgb = w_color;

    for (genvar g = 0; g < RD_PORTS; g++) begin : g_idx
        assign w_rd_idx[g] = w_src[8*g +: 8];
    end

    pbf_palette u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_pal_wr),
        .i_rd_en   (w_adv1),
        .i_rd_idx  (w_rd_idx),
        .o_rd_data (w_rd_data)
    );

    // ---------------- region start: clip and base address ----------------
    logic signed [12:0] w_left, w_top, w_right, w_bottom;
    logic signed [13:0] w_w, w_h;
    logic               w_reg_ok, w_reg_full;
    logic [ADDR_W-1:0]  w_buf_base;
    logic [24:0]        w_top_off;
    logic [ADDR_W-1:0]  w_reg_addr;

    always_comb begin
        w_left   = (w_rl > 13'sd0) ? w_rl : 13'sd0;
        w_top    = (w_rt > 13'sd0) ? w_rt : 13'sd0;
        w_right  = (w_rr < $signed({1'b0, w_sw})) ? w_rr : $signed({1'b0, w_sw});
        w_bottom = (w_rb < $signed({1'b0, w_sh})) ? w_rb : $signed({1'b0, w_sh});
        w_w      = 14'(w_right) - 14'(w_left);
        w_h      = 14'(w_bottom) - 14'(w_top);
        w_reg_ok = (w_bpp == 2'd1 || w_bpp == 2'd2) && (w_w > 14'sd0) && (w_h > 14'sd0);
        w_reg_full = (w_w == $signed({2'b00, w_sw})) && (w_h == $signed({2'b00, w_sh}));
    end

    // Buffer base: index is at most three, so shifts and an add
    always_comb begin
        case (r_buffer_index)
            2'd0:    w_buf_base = '0;
            2'd1:    w_buf_base = r_frame_size;
            2'd2:    w_buf_base = {r_frame_size[ADDR_W-2:0], 1'b0};
            default: w_buf_base = r_frame_size + {r_frame_size[ADDR_W-2:0], 1'b0};
        endcase
    end

    assign w_top_off  = w_top[11:0] * r_dst_pitch;
    assign w_reg_addr = w_buf_base + ADDR_W'(w_top_off) + ADDR_W'(w_left[11:0]);

    // ---------------- pixel group: lane count and walk ----------------
    logic [2:0]        w_cap, w_n;
    logic [12:0]       w_left_in_row, w_col_sum;
    logic              w_row_end, w_last, w_flip;
    logic [2:0]        w_nb;
    logic [PAN_W-1:0]  w_pan;
    logic [1:0]        w_bi_inc;

    always_comb begin
        w_cap = r_mode16 ? 3'd2 : 3'd4;
        if (LANES < 4 && 3'(LANES) < w_cap) begin
            w_cap = 3'(LANES);
        end
        w_n = (w_lanes_in > w_cap) ? w_cap : w_lanes_in;
        w_left_in_row = r_width - r_column;
        if ({10'd0, w_n} > w_left_in_row) begin
            w_n = w_left_in_row[2:0];
        end
        w_col_sum = r_column + {10'd0, w_n};
        w_row_end = (w_col_sum >= r_width);
        w_last    = w_row_end && (r_rows == 13'd1);

        // Effective buffer count: clamp above, zero acts as one
        if ({1'b0, r_buffer_count} > 3'(MAX_BUFFERS)) begin
            w_nb = 3'(MAX_BUFFERS);
        end else if (r_buffer_count == 2'd0) begin
            w_nb = 3'd1;
        end else begin
            w_nb = {1'b0, r_buffer_count};
        end
        w_flip   = w_last && r_full && (w_nb > 3'd1);
        w_pan    = w_flip ? PAN_W'(r_buffer_index) * PAN_W'(r_frame_height) : '0;
        w_bi_inc = r_buffer_index + 2'd1;
    end

    // ---------------- region state next values ----------------
    logic w_pix_go;
    assign w_pix_go = (s_axis_tuser == ACT_PIXELS) && r_active && (w_lanes_in != 3'd0);

    always_comb begin
        n_buffer_index = r_buffer_index;
        n_active       = r_active;
        n_mode16       = r_mode16;
        n_full         = r_full;
        n_width        = r_width;
        n_rows         = r_rows;
        n_column       = r_column;
        n_row_addr     = r_row_addr;
        if (s_axis_tuser == ACT_REGION) begin
            n_column = '0;
            n_active = w_reg_ok;
            if (w_reg_ok) begin
                n_mode16   = (w_bpp == 2'd2);
                n_full     = w_reg_full;
                n_width    = w_w[12:0];
                n_rows     = w_h[12:0];
                n_row_addr = w_reg_addr;
            end else begin
                n_width = '0;
                n_rows  = '0;
            end
        end else if (w_pix_go) begin
            n_column = w_col_sum;
            if (w_row_end) begin
                n_column   = '0;
                n_row_addr = r_row_addr + ADDR_W'(r_dst_pitch);
                n_rows     = r_rows - 13'd1;
                if (w_last) begin
                    n_active = 1'b0;
                end
                if (w_flip) begin
                    n_buffer_index = ({1'b0, w_bi_inc} >= w_nb) ? 2'd0 : w_bi_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_index <= '0;
            r_active       <= 1'b0;
            r_mode16       <= 1'b0;
            r_full         <= 1'b0;
            r_width        <= '0;
            r_rows         <= '0;
            r_column       <= '0;
            r_row_addr     <= '0;
        end else if (w_accept) begin
            r_buffer_index <= n_buffer_index;
            r_active       <= n_active;
            r_mode16       <= n_mode16;
            r_full         <= n_full;
            r_width        <= n_width;
            r_rows         <= n_rows;
            r_column       <= n_column;
            r_row_addr     <= n_row_addr;
        end
    end

    // ---------------- middle stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= w_accept && w_pix_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_addr   <= r_row_addr + ADDR_W'(r_column);
            r_s1_count  <= w_n;
            r_s1_last   <= w_last;
            r_s1_flip   <= w_flip;
            r_s1_pan    <= w_pan;
            r_s1_mode16 <= r_mode16;
            r_s1_src    <= w_src;
        end
    end

    // Lane assembly: palette colours or direct pixels, unused lanes zero
    logic [WORD_LANES-1:0][15:0] w_lut;
    logic [63:0]                 w_src64, w_s1_data;

    for (genvar g = 0; g < WORD_LANES; g++) begin : g_lut
        if (g < RD_PORTS) begin : g_rd
            assign w_lut[g] = w_rd_data[g];
        end else begin : g_none
            assign w_lut[g] = 16'h0000;
        end
    end

    assign w_src64 = {32'd0, r_s1_src};

    always_comb begin
        w_s1_data = '0;
        for (int i = 0; i < WORD_LANES; i++) begin
            if (3'(i) < r_s1_count) begin
                w_s1_data[16*i +: 16] = r_s1_mode16 ? w_src64[16*i +: 16] : w_lut[i];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_out_addr  <= r_s1_addr;
            r_out_data  <= w_s1_data;
            r_out_count <= r_s1_count;
            r_out_last  <= r_s1_last;
            r_out_flip  <= r_s1_flip;
            r_out_pan   <= r_s1_pan;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_pan, r_out_count, r_out_data, r_out_addr};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_flip;

endmodule

// ----- sv/pbf_palette.sv -----
// ---------------------------------------------------------------------------
// pbf_palette: RGB565 palette store
// One synchronous memory copy per read lane, all written together, with a
// valid bit per entry so that reset clears the whole palette at once.
// ---------------------------------------------------------------------------
module pbf_palette (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pbf_pkg::t_pal_wr                      i_wr,
    input  logic                                  i_rd_en,
    input  logic [pbf_pkg::RD_PORTS-1:0][7:0]     i_rd_idx,
    output logic [pbf_pkg::RD_PORTS-1:0][15:0]    o_rd_data
);
    import pbf_pkg::*;

    logic                 r_vld [PALETTE_ENTRIES];
    logic                 w_wr_ok;
    logic [PAL_AW-1:0]    w_wr_addr;

    // Writes beyond the palette are ignored
    assign w_wr_ok   = i_wr.en && ({1'b0, i_wr.idx} < 9'(PALETTE_ENTRIES));
    assign w_wr_addr = i_wr.idx[PAL_AW-1:0];

    // Entry valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < PALETTE_ENTRIES; e++) begin
                r_vld[e] <= 1'b0;
            end
        end else if (w_wr_ok) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    // One memory copy per lane
    for (genvar g = 0; g < RD_PORTS; g++) begin : g_lane
        logic [15:0]       mem [PALETTE_ENTRIES];
        logic [15:0]       r_rd;
        logic              r_hit;
        logic [PAL_AW-1:0] w_addr;

        assign w_addr = i_rd_idx[g][PAL_AW-1:0];

        always_ff @(posedge i_clk) begin
            if (w_wr_ok) begin
                mem[w_wr_addr] <= rgb565(i_wr.rgb);
            end
        end

        // Registered read; unwritten or out-of-range entries read as zero
        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                r_rd  <= mem[w_addr];
                r_hit <= ({1'b0, i_rd_idx[g]} < 9'(PALETTE_ENTRIES)) && r_vld[w_addr];
            end
        end

        assign o_rd_data[g] = r_hit ? r_rd : 16'h0000;
    end

endmodule

// ----- sv/pbf_checker.sv -----
// ---------------------------------------------------------------------------
// pbf_checker: port-level checks for the blitter
// Watches the output stream for flip, count and pan consistency.
// ---------------------------------------------------------------------------
module pbf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pbf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tuser
);
    import pbf_pkg::*;

    // Nothing leaves the block in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown straight after reset");

    // A flip only ever comes with the final group of a region
    a_flip_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("flip without region end");

    // Pixel count is one to four
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[92:90] != 3'd0) && (m_axis_tdata[92:90] <= 3'd4))
        else $error("pixel count out of range");

    // Pan offset is zero unless a flip is requested
    a_pan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[106:93] == '0))
        else $error("pan offset without flip");

    // Stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output changed");

endmodule

bind palette_blit_to_framebuffer pbf_checker u_pbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/palette_blit_to_framebuffer_test.sv -----
// ---------------------------------------------------------------------------
// palette_blit_to_framebuffer_test: self-checking bench for the blitter
// Drives palette writes, region starts and pixel groups on the input stream
// with random gaps, stalls the output stream at random, and checks every
// framebuffer write against a cycle-free model of the palette, the clipped
// row/column walk and the page-flip bookkeeping.
// ---------------------------------------------------------------------------
module palette_blit_to_framebuffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pbf_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;   // no such action, must be ignored
    localparam int CYCLE_LIMIT = 200000;

    // Input tdata layout, lowest field last
    typedef struct packed {
        logic [6:0]  pad;
        logic [2:0]  lane_count;
        logic [31:0] src_word;
        logic [1:0]  bpp;
        logic [11:0] surf_h;
        logic [11:0] surf_w;
        logic [12:0] rect_b;
        logic [12:0] rect_r;
        logic [12:0] rect_t;
        logic [12:0] rect_l;
        logic [23:0] color_rgb;
        logic [7:0]  pal_index;
    } blit_item_t;

    // Output tdata layout, lowest field last
    typedef struct packed {
        logic [4:0]  pad;
        logic [13:0] pan;
        logic [2:0]  count;
        logic [63:0] data;
        logic [25:0] addr;
    } blit_out_t;

    // One expected framebuffer write
    typedef struct packed {
        logic [25:0] addr;
        logic [63:0] data;
        logic [2:0]  count;
        logic        last;
        logic        flip;
        logic [13:0] pan;
    } fb_write_t;

    // DUT signals
    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [1:0]           i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;

    // Bench state
    fb_write_t fb_write_q[$];
    int        n_mismatches = 0;
    int        n_items_sent = 0;
    int        n_cycles     = 0;
    bit        tx_steady    = 1'b0;
    bit        rx_steady    = 1'b0;
    blit_out_t got_word;
    fb_write_t want;

    // Shadow of the block: registers, palette and walk state
    logic [12:0] m_pitch    = RST_DST_PITCH;
    logic [12:0] m_height   = RST_FRAME_HEIGHT;
    logic [1:0]  m_bcount   = RST_BUFFER_COUNT;
    logic [15:0] pal_m[PALETTE_ENTRIES];
    logic [1:0]  m_buf      = '0;
    bit          m_active   = 1'b0;
    bit          m_mode16   = 1'b0;
    bit          m_full     = 1'b0;
    logic [12:0] m_width    = '0;
    logic [12:0] m_rows     = '0;
    logic [12:0] m_col      = '0;
    logic [25:0] m_row_addr = '0;

    palette_blit_to_framebuffer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("palette_blit_to_framebuffer_test NOT OK");
        $finish;
    end

    // Output back-pressure
    always @(negedge i_clk)
        m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= 13);

    // Compare each output transaction with the oldest expected write
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_word = m_axis_tdata;
            if (fb_write_q.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= 10)
                    $display("unexpected write: addr %h data %h count %0d",
                             got_word.addr, got_word.data, got_word.count);
            end else begin
                want = fb_write_q.pop_front();
                if (got_word.addr !== want.addr || got_word.data !== want.data ||
                    got_word.count !== want.count || got_word.pan !== want.pan ||
                    m_axis_tlast !== want.last || m_axis_tuser !== want.flip) begin
                    n_mismatches++;
                    if (n_mismatches <= 10) begin
                        $display("write mismatch: exp addr %h data %h cnt %0d last %b flip %b pan %0d",
                                 want.addr, want.data, want.count, want.last, want.flip, want.pan);
                        $display("                got addr %h data %h cnt %0d last %b flip %b pan %0d",
                                 got_word.addr, got_word.data, got_word.count, m_axis_tlast,
                                 m_axis_tuser, got_word.pan);
                    end
                end
            end
        end
    end

    // Shadow update for one accepted input transaction
    task automatic predict_fb_write(input logic [1:0] act, input blit_item_t it);
        int          sw, sh, cl, ct, cr, cb, w, h, n, cap, room, nb;
        longint unsigned base;
        fb_write_t   r;
        case (act)
            ACT_PAL_WR: begin
                pal_m[it.pal_index] = {it.color_rgb[23:19], it.color_rgb[15:10],
                                       it.color_rgb[7:3]};
            end
            ACT_REGION: begin
                sw = int'(it.surf_w);
                sh = int'(it.surf_h);
                cl = int'($signed(it.rect_l));
                ct = int'($signed(it.rect_t));
                cr = int'($signed(it.rect_r));
                cb = int'($signed(it.rect_b));
                if (cl < 0) cl = 0;
                if (ct < 0) ct = 0;
                if (cr > sw) cr = sw;
                if (cb > sh) cb = sh;
                w = cr - cl;
                h = cb - ct;
                m_active = 1'b0;
                m_col    = '0;
                if (!(it.bpp == 2'd1 || it.bpp == 2'd2) || w <= 0 || h <= 0) begin
                    m_width = '0;
                    m_rows  = '0;
                end else begin
                    m_active = 1'b1;
                    m_mode16 = (it.bpp == 2'd2);
                    m_full   = (w == sw) && (h == sh);
                    m_width  = 13'(w);
                    m_rows   = 13'(h);
                    base = 64'(m_buf) * 64'(m_pitch) * 64'(m_height) +
                           64'(ct) * 64'(m_pitch) + 64'(cl);
                    m_row_addr = base[25:0];
                end
            end
            ACT_PIXELS: begin
                n = int'(it.lane_count);
                if (m_active && n != 0) begin
                    cap = m_mode16 ? 2 : 4;
                    if (cap > LANES) cap = LANES;
                    if (n > cap) n = cap;
                    room = int'(m_width) - int'(m_col);
                    if (n > room) n = room;
                    r = '0;
                    for (int i = 0; i < n; i++)
                        r.data[16*i +: 16] = m_mode16 ? it.src_word[16*i +: 16]
                                                      : pal_m[it.src_word[8*i +: 8]];
                    r.addr  = m_row_addr + 26'(m_col);
                    r.count = 3'(n);
                    m_col   = m_col + 13'(n);
                    if (m_col >= m_width) begin
                        m_col      = '0;
                        m_row_addr = m_row_addr + 26'(m_pitch);
                        m_rows     = m_rows - 13'd1;
                        if (m_rows == 0) begin
                            // zero buffers behaves as one, above the maximum is capped
                            nb = (m_bcount == 0) ? 1 :
                                 (int'(m_bcount) > MAX_BUFFERS) ? MAX_BUFFERS : int'(m_bcount);
                            r.last   = 1'b1;
                            m_active = 1'b0;
                            if (m_full && nb > 1) begin
                                r.flip = 1'b1;
                                r.pan  = 14'(m_buf) * 14'(m_height);
                                m_buf  = m_buf + 2'd1;
                                if (int'(m_buf) >= nb) m_buf = '0;
                            end
                        end
                    end
                    fb_write_q.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // Every field random, so that unused fields toggle too
    function automatic blit_item_t random_item();
        blit_item_t it;
        it = S_TDATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        it.pad = '0;
        return it;
    endfunction

    // One input transaction, with a random gap in front; returns at a falling edge
    task automatic send_item(input logic [1:0] act, input blit_item_t it);
        while (!tx_steady && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = it;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        predict_fb_write(act, it);
        n_items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_pal(input int idx, input int rgb);
        blit_item_t it;
        it = random_item();
        it.pal_index = 8'(idx);
        it.color_rgb = 24'(rgb);
        send_item(ACT_PAL_WR, it);
    endtask

    task automatic send_region(input int l, input int t, input int r, input int b,
                               input int sw, input int sh, input int bpp);
        blit_item_t it;
        it = random_item();
        it.rect_l = 13'(l);
        it.rect_t = 13'(t);
        it.rect_r = 13'(r);
        it.rect_b = 13'(b);
        it.surf_w = 12'(sw);
        it.surf_h = 12'(sh);
        it.bpp    = 2'(bpp);
        send_item(ACT_REGION, it);
    endtask

    task automatic send_pixels(input logic [31:0] src, input int lanes);
        blit_item_t it;
        it = random_item();
        it.src_word   = src;
        it.lane_count = 3'(lanes);
        send_item(ACT_PIXELS, it);
    endtask

    // Stop sending and let every expected write come out, plus pipeline slack
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (fb_write_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        i_cfg_wr_en   = 1'b1;
        i_cfg_index   = idx;
        i_cfg_wr_data = val;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        case (idx)
            CFG_DST_PITCH:    m_pitch  = val;
            CFG_FRAME_HEIGHT: m_height = val;
            CFG_BUFFER_COUNT: m_bcount = val[1:0];
            default: ;
        endcase
    endtask

    // Close any open walk, drain, then load all three registers
    task automatic set_config(input logic [12:0] pitch, input logic [12:0] height,
                              input logic [1:0] bc);
        if (m_active) send_region(0, 0, 0, 0, 0, 0, 0);
        drain_results();
        write_reg(CFG_DST_PITCH, pitch);
        write_reg(CFG_FRAME_HEIGHT, height);
        write_reg(CFG_BUFFER_COUNT, {11'b0, bc});
    endtask

    // Palette is clear after reset; lane count cut at the row end
    task automatic test_reset_state();
        send_region(-5, -5, 100, 100, 2, 1, 1);
        send_pixels($urandom(), 4);
    endtask

    // Colour conversion at the extremes and lookup of all four lanes
    task automatic test_palette();
        send_pal(0, 24'hFFFFFF);
        send_pal(255, 24'h123456);
        send_pal(128, 24'h0804F8);
        send_region(0, 0, 4, 1, 4, 1, 1);
        send_pixels({8'd7, 8'd128, 8'd255, 8'd0}, 4);
    endtask

    // 16-bit copy on a clipped window: lane cut to two, to the row, zero dropped
    task automatic test_direct_pixels();
        send_region(2, 3, 5, 5, 10, 10, 2);
        send_pixels($urandom(), 4);
        send_pixels($urandom(), 7);
        send_pixels($urandom(), 0);
        send_pixels($urandom(), 1);
        send_pixels($urandom(), 2);
    endtask

    // Bad depth, empty clip, idle pixels, unknown action, abandoned region
    task automatic test_clip_cases();
        send_region(0, 0, 4, 4, 4, 4, 0);
        send_pixels($urandom(), 1);
        send_region(0, 0, 4, 4, 4, 4, 3);
        send_region(3, 0, 2, 4, 8, 8, 1);
        send_region(0, 0, 4, 4, 0, 4, 1);
        send_pixels($urandom(), 4);
        send_item(ACT_UNKNOWN, random_item());
        send_region(-4096, -4096, 4095, 4095, 3, 2, 1);
        send_pixels($urandom(), 3);
        send_region(1, 1, 3, 3, 4, 4, 2);
        send_pixels($urandom(), 2);
        send_pixels($urandom(), 2);
        send_pixels($urandom(), 2);
    endtask

    // Flip on full-surface regions, buffer index wrap, zero buffers, partial region
    task automatic test_page_flip();
        set_config(13'd800, 13'd600, 2'd3);
        repeat (4) begin
            send_region(0, 0, 1, 1, 1, 1, 1);
            send_pixels($urandom(), 1);
        end
        set_config(13'd800, 13'd600, 2'd0);
        send_region(0, 0, 1, 1, 1, 1, 2);
        send_pixels($urandom(), 1);
        set_config(13'd800, 13'd600, 2'd2);
        send_region(0, 0, 1, 1, 2, 1, 1);
        send_pixels($urandom(), 1);
    endtask

    // Largest register values on the last buffer, so the address wraps
    task automatic test_address_wrap();
        set_config(13'h1FFF, 13'h1FFF, 2'd3);
        while (m_buf != 2'd2) begin
            send_region(0, 0, 1, 1, 1, 1, 1);
            send_pixels($urandom(), 1);
        end
        send_region(4093, 4094, 4095, 4095, 4095, 4095, 2);
        send_pixels($urandom(), 2);
    endtask

    // One region start followed mostly by the groups that complete it
    task automatic run_region_seq();
        int kind, sw, sh, l, t, w, h, bpp, lanes, groups, cutoff;
        kind = $urandom_range(0, 99);
        bpp  = $urandom_range(1, 2);
        if ($urandom_range(0, 9) == 0) bpp = $urandom_range(0, 1) ? 0 : 3;
        if (kind < 40) begin
            // full surface, small
            sw = $urandom_range(1, 6);
            sh = $urandom_range(1, 6);
            send_region(-int'($urandom_range(0, 4096)), -int'($urandom_range(0, 4096)),
                        sw + int'($urandom_range(0, 4095 - sw)),
                        sh + int'($urandom_range(0, 4095 - sh)), sw, sh, bpp);
        end else if (kind < 85) begin
            // small window somewhere on a surface of any size
            sw = $urandom_range(0, 4095);
            sh = $urandom_range(0, 4095);
            l  = $urandom_range(0, sw);
            t  = $urandom_range(0, sh);
            w  = $urandom_range(1, 8);
            h  = $urandom_range(1, 6);
            send_region(l, t, (l + w > 4095) ? 4095 : l + w,
                        (t + h > 4095) ? 4095 : t + h, sw, sh, bpp);
        end else begin
            send_region(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                        int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                        $urandom_range(0, 4095), $urandom_range(0, 4095), bpp);
        end
        // now and then break off early
        cutoff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 96;
        groups = 0;
        while (m_active && groups < cutoff) begin
            lanes = $urandom_range(1, 4);
            if ($urandom_range(0, 9) == 0) begin
                lanes = $urandom_range(4, 7);
                if (lanes == 4) lanes = 0;
            end
            send_pixels($urandom(), lanes);
            groups++;
        end
    endtask

    task automatic test_random_phase(input logic [12:0] pitch, input logic [12:0] height,
                                     input logic [1:0] bc, input int n_items, input bit steady);
        int start, k;
        set_config(pitch, height, bc);
        tx_steady = steady;
        rx_steady = steady;
        start = n_items_sent;
        while (n_items_sent - start < n_items) begin
            k = $urandom_range(0, 99);
            if (k < 12)
                send_pal($urandom_range(0, 255), $urandom_range(0, 24'hFFFFFF));
            else if (k < 16)
                send_item(ACT_UNKNOWN, random_item());
            else if (k < 20)
                send_pixels($urandom(), $urandom_range(0, 7));
            else
                run_region_seq();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Main sequence
    initial begin
        foreach (pal_m[i]) pal_m[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_palette();
        test_direct_pixels();
        test_clip_cases();
        test_page_flip();
        test_address_wrap();
        test_random_phase(RST_DST_PITCH, RST_FRAME_HEIGHT, RST_BUFFER_COUNT, 250, 1'b0);
        test_random_phase(13'd1, 13'd1, 2'd2, 250, 1'b0);
        test_random_phase(13'd4096, 13'd4096, 2'd3, 250, 1'b1);
        test_random_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                          2'($urandom_range(0, 3)), 250, 1'b0);

        drain_results();
        repeat (8) @(negedge i_clk);
        if (n_mismatches == 0 && fb_write_q.size() == 0)
            $display("palette_blit_to_framebuffer_test OK");
        else
            $display("palette_blit_to_framebuffer_test NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/pbf_pkg.sv
sv/pbf_palette.sv
sv/palette_blit_to_framebuffer.sv
sv/pbf_checker.sv
tb/sv/palette_blit_to_framebuffer_test.sv
